[hdl/m3kt_pkg.sv]
// Package with shared constants, types and hash helpers for the key table.
package m3kt_pkg;

  localparam int TableSlots = 1024;
  localparam int KeyBytes = 16;
  localparam int SlotBits = $clog2(TableSlots);
  localparam int CountBits = $clog2(TableSlots + 1);
  localparam int EntryWidth = 64 + 56 + 32 + 1;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StDuplicate = 3'd2;
  localparam logic [2:0] StFull = 3'd3;
  localparam logic [2:0] StTooLong = 3'd4;

  localparam logic OpInsert = 1'b0;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] C3 = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_LOAD, S_HMUL1, S_HMUL2, S_HMIX, S_FMUL1, S_FMUL2,
    S_READ, S_WAIT, S_CHECK, S_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic hmul1;
    logic hmul2;
    logic hmix;
    logic fmul1;
    logic fmul2;
    logic write;
    logic advance;
    logic finish;
    logic [2:0] fin_status;
    logic fin_found;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic too_long;
    logic is_insert;
    logic table_full;
    logic last_block;
    logic has_tail;
    logic slot_used;
    logic key_match;
    logic probed_all;
    logic out_busy;
  } stat_t;

endpackage

[hdl/m3kt_if.sv]
// Valid-ready channel interface carrying one payload.
interface m3kt_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/m3kt_ram.sv]
// Generic single-port RAM with registered read.
module m3kt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[hdl/m3kt_ctrl.sv]
// Controller state machine sequencing clearing, hashing and probing.
module m3kt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  m3kt_pkg::stat_t stat,
  output m3kt_pkg::cmd_t  cmd
);
  m3kt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m3kt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      m3kt_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = m3kt_pkg::S_IDLE;
      end
      m3kt_pkg::S_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && !stat.out_busy) begin
          cmd.load = 1'b1;
          state_next = m3kt_pkg::S_LOAD;
        end
      end
      m3kt_pkg::S_LOAD: begin
        if (stat.too_long) begin
          cmd.finish = 1'b1;
          cmd.fin_status = m3kt_pkg::StTooLong;
          state_next = m3kt_pkg::S_IDLE;
        end else if (stat.last_block && !stat.has_tail) begin
          state_next = m3kt_pkg::S_FMUL1;
          cmd.hmix = 1'b1;
        end else begin
          state_next = m3kt_pkg::S_HMUL1;
        end
      end
      m3kt_pkg::S_HMUL1: begin
        cmd.hmul1 = 1'b1;
        state_next = m3kt_pkg::S_HMUL2;
      end
      m3kt_pkg::S_HMUL2: begin
        cmd.hmul2 = 1'b1;
        state_next = m3kt_pkg::S_HMIX;
      end
      m3kt_pkg::S_HMIX: begin
        cmd.hmix = 1'b1;
        if (stat.last_block) state_next = m3kt_pkg::S_FMUL1;
        else state_next = m3kt_pkg::S_HMUL1;
      end
      m3kt_pkg::S_FMUL1: begin
        cmd.fmul1 = 1'b1;
        state_next = m3kt_pkg::S_FMUL2;
      end
      m3kt_pkg::S_FMUL2: begin
        cmd.fmul2 = 1'b1;
        if (stat.is_insert && stat.table_full) begin
          cmd.finish = 1'b1;
          cmd.fin_status = m3kt_pkg::StFull;
          state_next = m3kt_pkg::S_IDLE;
        end else begin
          state_next = m3kt_pkg::S_READ;
        end
      end
      m3kt_pkg::S_READ: begin
        state_next = m3kt_pkg::S_WAIT;
      end
      m3kt_pkg::S_WAIT: begin
        state_next = m3kt_pkg::S_CHECK;
      end
      m3kt_pkg::S_CHECK: begin
        state_next = m3kt_pkg::S_IDLE;
        if (!stat.slot_used) begin
          cmd.finish = 1'b1;
          if (stat.is_insert) begin
            cmd.write = 1'b1;
            cmd.fin_status = m3kt_pkg::StOk;
          end else begin
            cmd.fin_status = m3kt_pkg::StNotFound;
          end
        end else if (stat.key_match) begin
          cmd.finish = 1'b1;
          if (stat.is_insert) begin
            cmd.fin_status = m3kt_pkg::StDuplicate;
          end else begin
            cmd.fin_status = m3kt_pkg::StOk;
            cmd.fin_found = 1'b1;
          end
        end else if (stat.probed_all) begin
          cmd.finish = 1'b1;
          cmd.fin_status = stat.is_insert ? m3kt_pkg::StFull : m3kt_pkg::StNotFound;
        end else begin
          cmd.advance = 1'b1;
          state_next = m3kt_pkg::S_READ;
        end
      end
      default: state_next = m3kt_pkg::S_IDLE;
    endcase
  end
endmodule

[hdl/m3kt_dp.sv]
// Datapath: hash unit, slot memory, probe address and result register.
module m3kt_dp (
  input  logic            clk,
  input  logic            rst,
  input  m3kt_pkg::cmd_t  cmd,
  output m3kt_pkg::stat_t stat,
  input  logic            in_op,
  input  logic [63:0]     in_key_word0,
  input  logic [55:0]     in_key_word1,
  input  logic [4:0]      in_key_length,
  input  logic [31:0]     in_value,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_status,
  output logic [31:0]     out_found_value,
  output logic [10:0]     out_entry_count
);
  logic        op;
  logic [63:0] w0;
  logic [55:0] w1;
  logic [4:0]  len;
  logic [31:0] val;
  logic [1:0]  blk;
  logic [31:0] h, k, hf1, hf2;
  logic [m3kt_pkg::SlotBits-1:0] slot, clr_addr;
  logic [m3kt_pkg::SlotBits:0]   probes;
  logic [m3kt_pkg::CountBits-1:0] filled;
  logic [63:0] mask0;
  logic [55:0] mask1;
  logic [127:0] kcat;
  logic [31:0] blkword, kr, tmp;
  logic [1:0]  nblocks;
  logic        we;
  logic [m3kt_pkg::SlotBits-1:0] addr;
  logic [m3kt_pkg::EntryWidth-1:0] wdata, rdata;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask0[8*i +: 8] = (5'(i) < in_key_length) ? 8'hff : 8'h00;
    end
    for (int i = 0; i < 7; i++) begin
      mask1[8*i +: 8] = (5'(i + 8) < in_key_length) ? 8'hff : 8'h00;
    end
  end

  assign kcat = {8'h00, w1, w0};
  assign blkword = kcat[32*blk +: 32];
  assign nblocks = len[3:2];
  assign kr = {k[16:0], k[31:17]};
  assign tmp = h ^ k;
  assign hf1 = h * m3kt_pkg::F1;
  assign hf2 = h * m3kt_pkg::F2;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      w0 <= in_key_word0 & mask0;
      w1 <= in_key_word1 & mask1;
      len <= in_key_length;
      val <= in_value;
      blk <= 2'd0;
      h <= '0;
    end
    if (cmd.hmul1) k <= blkword * m3kt_pkg::C1;
    if (cmd.hmul2) k <= kr * m3kt_pkg::C2;
    if (cmd.hmix) begin
      if (blk == nblocks) begin
        if (len[1:0] == 2'd0) begin
          h <= (h ^ 32'(len)) ^ ((h ^ 32'(len)) >> 16);
        end else begin
          h <= (h ^ k ^ 32'(len)) ^ ((h ^ k ^ 32'(len)) >> 16);
        end
      end else begin
        h <= {tmp[18:0], tmp[31:19]} * 32'd5 + m3kt_pkg::C3;
        blk <= blk + 2'd1;
      end
    end
    if (cmd.fmul1) begin
      h <= hf1 ^ (hf1 >> 13);
    end
    if (cmd.fmul2) begin
      slot <= m3kt_pkg::SlotBits'(hf2 ^ (hf2 >> 16));
      probes <= '0;
    end
    if (cmd.advance) begin
      slot <= slot + 1'b1;
      probes <= probes + 1'b1;
    end
  end

  // The tail block is mixed through the same multiplier path as full blocks.
  assign stat.last_block = (blk == nblocks);
  assign stat.has_tail = (len[1:0] != 2'd0);
  assign stat.too_long = (len > 5'(m3kt_pkg::KeyBytes - 1));
  assign stat.is_insert = (op == m3kt_pkg::OpInsert);
  assign stat.table_full = (filled >= m3kt_pkg::CountBits'(m3kt_pkg::TableSlots));
  assign stat.slot_used = rdata[m3kt_pkg::EntryWidth-1];
  assign stat.key_match = (rdata[151:32] == {w1, w0});
  assign stat.probed_all = (probes == (m3kt_pkg::SlotBits+1)'(m3kt_pkg::TableSlots - 1));
  assign stat.clear_last = (clr_addr == m3kt_pkg::SlotBits'(m3kt_pkg::TableSlots - 1));
  assign stat.out_busy = out_valid;

  assign we = cmd.clear_step | cmd.write;
  assign addr = cmd.clear_step ? clr_addr : slot;
  assign wdata = cmd.clear_step ? '0 : {1'b1, w1, w0, val};

  m3kt_ram #(.Width(m3kt_pkg::EntryWidth), .Depth(m3kt_pkg::TableSlots)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      filled <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.write) filled <= filled + 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        out_status <= cmd.fin_status;
        out_found_value <= cmd.fin_found ? rdata[31:0] : 32'd0;
        out_entry_count <= 11'(filled + (cmd.write ? 1'b1 : 1'b0));
      end
    end
  end
endmodule

[hdl/murmur3_linear_probe_key_table_top.sv]
// Top level of the MurmurHash3 linear-probing key table.
//
//   channel | direction | payload
//   req     | in        | op, key_word0, key_word1, key_length, value
//   rsp     | out       | status, found_value, entry_count
//
// One request at a time. A key is loaded and each full block multiplied and
// mixed, the last pass mixing the tail or nothing; the hash is then finalized
// and each probed slot is read through the single slot memory port. All 1024
// slots are cleared after reset before the first request is taken.
// The result register holds a response until taken; no new request is taken
// while it is full.
module murmur3_linear_probe_key_table_top (
  input logic clk,
  input logic rst,
  m3kt_if.sink   req,
  m3kt_if.source rsp
);
  m3kt_pkg::cmd_t  cmd;
  m3kt_pkg::stat_t stat;

  m3kt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .stat(stat), .cmd(cmd)
  );

  m3kt_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_op(req.payload.op), .in_key_word0(req.payload.key_word0),
    .in_key_word1(req.payload.key_word1), .in_key_length(req.payload.key_length),
    .in_value(req.payload.value),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_status(rsp.payload.status), .out_found_value(rsp.payload.found_value),
    .out_entry_count(rsp.payload.entry_count)
  );
endmodule
